>>> rtl/core/slm_pkg.sv
// shared types, constants and command codes of the sprite line mapper
`default_nettype none

package slm_pkg;

    // default sizes
    localparam int SLM_SPRITE_ENTRIES = 40;
    localparam int SLM_VISIBLE_LINES  = 144;
    localparam int SLM_LINE_LIMIT     = 10;

    // sprite geometry
    localparam int SLM_Y_OFFSET = 16;
    localparam int SLM_SHORT_H  = 8;
    localparam int SLM_TALL_H   = 16;

    // command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic [5:0] sprite_number;
        logic [7:0] vertical_position;
        logic [7:0] horizontal_position;
        logic       tall_sprite;
        logic [7:0] query_line;
    } slm_in_t;

    typedef struct packed {
        logic [5:0] found_sprite;
        logic       found;
        logic [3:0] line_count;
        logic       last;
    } slm_out_t;

    typedef struct packed {
        logic       tall;
        logic [7:0] x;
        logic [7:0] y;
    } slm_entry_t;

endpackage

`default_nettype wire

>>> rtl/core/slm_ram.sv
// generic simple dual port ram, one write port, one registered read port
`default_nettype none

module slm_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/core/sprite_line_mapper_top.sv
// top level of the sprite line mapper: sprite table, line map build and line query
//
//  channel | ports                         | direction | word
//  --------+-------------------------------+-----------+------------------------------
//  s_      | s_valid s_ready s_data        | in        | slm_in_t command word
//  m_      | m_valid m_ready m_data        | out       | slm_out_t result word (queries)
//  cfg_    | cfg_valid cfg_ready cfg_data  | in        | color_mode register word
//
// a write or an unknown command leaves the sequencer idle. a build reads each sprite entry in
//   turn, then steps through its covered rows, with a count read-modify-write on each visible line.
// a query reads the line count, then loads the list, table entry and key of each listed sprite,
//   then per result scans the listed sprites and sends one word; an empty line gives one word.
// s_ready is high only while the sequencer is idle; one command word at a time.
// reset clears the sequencer, the sprite valid bits and the line count valid bits;
//   no clearing pass, invalid entries read as zero.
// a stalled result word is held in the output register until m_ready.
`default_nettype none

module sprite_line_mapper_top
    import slm_pkg::*;
#(
    parameter int SPRITE_ENTRIES = SLM_SPRITE_ENTRIES,
    parameter int VISIBLE_LINES  = SLM_VISIBLE_LINES,
    parameter int LINE_LIMIT     = SLM_LINE_LIMIT
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire slm_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output slm_out_t      m_data,
    input  wire logic     cfg_valid,
    output logic          cfg_ready,
    input  wire logic     cfg_data
);

    // address and counter widths
    localparam int TAW = (SPRITE_ENTRIES > 1) ? $clog2(SPRITE_ENTRIES) : 1;
    localparam int LW  = (VISIBLE_LINES > 1) ? $clog2(VISIBLE_LINES) : 1;
    localparam int LAW = (VISIBLE_LINES * LINE_LIMIT > 1) ?
                         $clog2(VISIBLE_LINES * LINE_LIMIT) : 1;
    localparam int CW  = $clog2(LINE_LIMIT + 1);
    localparam int PW  = (LINE_LIMIT > 1) ? $clog2(LINE_LIMIT) : 1;

    // sequencer states
    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_B_RD   = 12'b0000_0000_0010,
        ST_B_ENT  = 12'b0000_0000_0100,
        ST_B_LINE = 12'b0000_0000_1000,
        ST_B_UPD  = 12'b0000_0001_0000,
        ST_Q_CNT  = 12'b0000_0010_0000,
        ST_Q_CHK  = 12'b0000_0100_0000,
        ST_Q_LIST = 12'b0000_1000_0000,
        ST_Q_TBL  = 12'b0001_0000_0000,
        ST_Q_KEY  = 12'b0010_0000_0000,
        ST_Q_SCAN = 12'b0100_0000_0000,
        ST_Q_OUT  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // control registers
    logic                      color_mode_reg, color_mode_next;
    logic [SPRITE_ENTRIES-1:0] tbl_valid_reg, tbl_valid_next;
    logic [VISIBLE_LINES-1:0]  cnt_valid_reg, cnt_valid_next;
    logic                      m_valid_reg, m_valid_next;
    logic [TAW-1:0]            s_cnt_reg, s_cnt_next;
    logic [3:0]                k_reg, k_next;
    logic [CW-1:0]             n_reg, n_next;
    logic [CW-1:0]             p_reg, p_next;
    logic [CW-1:0]             i_reg, i_next;
    logic                      have_best_reg, have_best_next;

    // payload registers
    logic [7:0]     y_reg, y_next;
    logic           tall_reg, tall_next;
    logic [LW-1:0]  line_reg, line_next;
    logic [7:0]     q_line_reg, q_line_next;
    logic [7:0]     best_key_reg, best_key_next;
    logic [PW-1:0]  best_pos_reg, best_pos_next;
    logic [TAW-1:0] best_id_reg, best_id_next;
    logic [7:0]     prev_key_reg, prev_key_next;
    logic [PW-1:0]  prev_pos_reg, prev_pos_next;
    slm_out_t       m_data_reg, m_data_next;
    logic           tbl_rv_reg, cnt_rv_reg;
    logic [TAW-1:0] list_reg [LINE_LIMIT];
    logic [7:0]     key_reg  [LINE_LIMIT];

    // memory ports
    logic             tbl_we;
    logic [TAW-1:0]   tbl_waddr, tbl_raddr;
    slm_entry_t       tbl_wdata, tbl_rdata, tbl_entry;
    logic             cnt_we;
    logic [LW-1:0]    cnt_raddr;
    logic [CW-1:0]    cnt_wdata, cnt_rdata, cnt_n;
    logic             list_we;
    logic [LAW-1:0]   list_waddr, list_raddr;
    logic [TAW-1:0]   list_rdata;

    // local helpers
    logic             s_acc;
    logic             list_load, key_load;
    logic [9:0]       line_sum, line_full;
    logic             line_vis;
    logic             k_done, s_done;
    logic [PW-1:0]    p_idx;
    logic             q_in_range;
    logic             elig, better, take;

    assign s_acc     = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

    // memories
    slm_ram #(.WIDTH($bits(slm_entry_t)), .DEPTH(SPRITE_ENTRIES)) u_tbl_ram (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (tbl_wdata),
        .rd_addr (tbl_raddr),
        .rd_data (tbl_rdata)
    );

    slm_ram #(.WIDTH(CW), .DEPTH(VISIBLE_LINES)) u_cnt_ram (
        .aclk    (aclk),
        .wr_en   (cnt_we),
        .wr_addr (line_reg),
        .wr_data (cnt_wdata),
        .rd_addr (cnt_raddr),
        .rd_data (cnt_rdata)
    );

    slm_ram #(.WIDTH(TAW), .DEPTH(VISIBLE_LINES * LINE_LIMIT)) u_list_ram (
        .aclk    (aclk),
        .wr_en   (list_we),
        .wr_addr (list_waddr),
        .wr_data (s_cnt_reg),
        .rd_addr (list_raddr),
        .rd_data (list_rdata)
    );

    // entries never written read as zero
    assign tbl_entry = tbl_rv_reg ? tbl_rdata : '0;
    assign cnt_n     = cnt_rv_reg ? cnt_rdata : '0;

    assign tbl_waddr = s_data.sprite_number[TAW-1:0];
    assign tbl_wdata = '{tall: s_data.tall_sprite,
                         x:    s_data.horizontal_position,
                         y:    s_data.vertical_position};

    // screen line covered by row k of the current sprite, y is line plus 16
    assign line_sum  = {2'b00, y_reg} + {6'b0, k_reg};
    assign line_full = line_sum - 10'(SLM_Y_OFFSET);
    assign line_vis  = (line_sum >= 10'(SLM_Y_OFFSET)) &&
                       (line_full < 10'(VISIBLE_LINES));
    assign k_done    = (k_reg == (tall_reg ? 4'(SLM_TALL_H - 1) : 4'(SLM_SHORT_H - 1)));
    assign s_done    = (s_cnt_reg == TAW'(SPRITE_ENTRIES - 1));

    assign list_waddr = LAW'(line_reg) * LAW'(LINE_LIMIT) + LAW'(cnt_n);
    assign list_raddr = LAW'(q_line_reg[LW-1:0]) * LAW'(LINE_LIMIT) + LAW'(p_reg);
    assign q_in_range = ({1'b0, q_line_reg} < 9'(VISIBLE_LINES));

    // shared compare unit of the sort scan: smallest (x, list position) above the
    // last word sent; color mode zeroes every key so list order falls out
    assign p_idx  = p_reg[PW-1:0];
    assign elig   = (i_reg == '0) ||
                    ({key_reg[p_idx], p_idx} > {prev_key_reg, prev_pos_reg});
    assign better = !have_best_reg || (key_reg[p_idx] < best_key_reg);
    assign take   = elig && better;

    always_comb begin
        state_next      = state_reg;
        color_mode_next = cfg_valid ? cfg_data : color_mode_reg;
        tbl_valid_next  = tbl_valid_reg;
        cnt_valid_next  = cnt_valid_reg;
        m_valid_next    = m_valid_reg;
        s_cnt_next      = s_cnt_reg;
        k_next          = k_reg;
        n_next          = n_reg;
        p_next          = p_reg;
        i_next          = i_reg;
        have_best_next  = have_best_reg;
        y_next          = y_reg;
        tall_next       = tall_reg;
        line_next       = line_reg;
        q_line_next     = q_line_reg;
        best_key_next   = best_key_reg;
        best_pos_next   = best_pos_reg;
        best_id_next    = best_id_reg;
        prev_key_next   = prev_key_reg;
        prev_pos_next   = prev_pos_reg;
        m_data_next     = m_data_reg;
        tbl_we          = 1'b0;
        tbl_raddr       = s_cnt_reg;
        cnt_we          = 1'b0;
        cnt_raddr       = line_reg;
        cnt_wdata       = cnt_n + CW'(1);
        list_we         = 1'b0;
        list_load       = 1'b0;
        key_load        = 1'b0;

        unique case (state_reg) inside
            ST_IDLE: begin
                if (s_acc) begin
                    unique case (s_data.command)
                        CMD_WRITE: begin
                            if ({2'b00, s_data.sprite_number} < 8'(SPRITE_ENTRIES)) begin
                                tbl_we                    = 1'b1;
                                tbl_valid_next[tbl_waddr] = 1'b1;
                            end
                        end
                        CMD_BUILD: begin
                            cnt_valid_next = '0;
                            s_cnt_next     = '0;
                            state_next     = ST_B_RD;
                        end
                        CMD_QUERY: begin
                            q_line_next = s_data.query_line;
                            state_next  = ST_Q_CNT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_B_RD: begin
                tbl_raddr  = s_cnt_reg;
                state_next = ST_B_ENT;
            end
            ST_B_ENT: begin
                y_next     = tbl_entry.y;
                tall_next  = tbl_entry.tall;
                k_next     = '0;
                state_next = ST_B_LINE;
            end
            ST_B_LINE, ST_B_UPD: begin
                if (state_reg == ST_B_LINE && line_vis) begin
                    cnt_raddr  = line_full[LW-1:0];
                    line_next  = line_full[LW-1:0];
                    state_next = ST_B_UPD;
                end else begin
                    if (state_reg == ST_B_UPD && cnt_n < CW'(LINE_LIMIT)) begin
                        list_we                  = 1'b1;
                        cnt_we                   = 1'b1;
                        cnt_valid_next[line_reg] = 1'b1;
                    end
                    // next row, next sprite or done
                    if (!k_done) begin
                        k_next     = k_reg + 4'd1;
                        state_next = ST_B_LINE;
                    end else if (s_done) begin
                        state_next = ST_IDLE;
                    end else begin
                        s_cnt_next = s_cnt_reg + TAW'(1);
                        state_next = ST_B_RD;
                    end
                end
            end
            ST_Q_CNT: begin
                cnt_raddr  = q_line_reg[LW-1:0];
                state_next = ST_Q_CHK;
            end
            ST_Q_CHK: begin
                if (!q_in_range || cnt_n == '0) begin
                    m_data_next  = '{found_sprite: 6'd0, found: 1'b0,
                                     line_count: 4'd0, last: 1'b1};
                    m_valid_next = 1'b1;
                    state_next   = ST_Q_OUT;
                end else begin
                    n_next     = cnt_n;
                    p_next     = '0;
                    i_next     = '0;
                    state_next = ST_Q_LIST;
                end
            end
            ST_Q_LIST: begin
                state_next = ST_Q_TBL;
            end
            ST_Q_TBL: begin
                list_load  = 1'b1;
                tbl_raddr  = list_rdata;
                state_next = ST_Q_KEY;
            end
            ST_Q_KEY: begin
                key_load = 1'b1;
                if (p_reg == n_reg - CW'(1)) begin
                    p_next         = '0;
                    have_best_next = 1'b0;
                    state_next     = ST_Q_SCAN;
                end else begin
                    p_next     = p_reg + CW'(1);
                    state_next = ST_Q_LIST;
                end
            end
            ST_Q_SCAN: begin
                if (take) begin
                    best_key_next  = key_reg[p_idx];
                    best_pos_next  = p_idx;
                    best_id_next   = list_reg[p_idx];
                    have_best_next = 1'b1;
                end
                if (p_reg == n_reg - CW'(1)) begin
                    m_data_next  = '{found_sprite: 6'(take ? list_reg[p_idx] : best_id_reg),
                                     found:        1'b1,
                                     line_count:   4'(n_reg),
                                     last:         (i_reg + CW'(1) == n_reg)};
                    m_valid_next = 1'b1;
                    state_next   = ST_Q_OUT;
                end else begin
                    p_next = p_reg + CW'(1);
                end
            end
            ST_Q_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_data_reg.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        i_next         = i_reg + CW'(1);
                        prev_key_next  = best_key_reg;
                        prev_pos_next  = best_pos_reg;
                        p_next         = '0;
                        have_best_next = 1'b0;
                        state_next     = ST_Q_SCAN;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            color_mode_reg <= 1'b0;
            tbl_valid_reg  <= '0;
            cnt_valid_reg  <= '0;
            m_valid_reg    <= 1'b0;
            s_cnt_reg      <= '0;
            k_reg          <= '0;
            n_reg          <= '0;
            p_reg          <= '0;
            i_reg          <= '0;
            have_best_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            color_mode_reg <= color_mode_next;
            tbl_valid_reg  <= tbl_valid_next;
            cnt_valid_reg  <= cnt_valid_next;
            m_valid_reg    <= m_valid_next;
            s_cnt_reg      <= s_cnt_next;
            k_reg          <= k_next;
            n_reg          <= n_next;
            p_reg          <= p_next;
            i_reg          <= i_next;
            have_best_reg  <= have_best_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        y_reg        <= y_next;
        tall_reg     <= tall_next;
        line_reg     <= line_next;
        q_line_reg   <= q_line_next;
        best_key_reg <= best_key_next;
        best_pos_reg <= best_pos_next;
        best_id_reg  <= best_id_next;
        prev_key_reg <= prev_key_next;
        prev_pos_reg <= prev_pos_next;
        m_data_reg   <= m_data_next;
        // valid bit of each read address travels with the registered read data
        tbl_rv_reg   <= tbl_valid_reg[tbl_raddr];
        cnt_rv_reg   <= cnt_valid_reg[cnt_raddr];
        if (list_load) begin
            list_reg[p_idx] <= list_rdata;
        end
        if (key_load) begin
            key_reg[p_idx] <= color_mode_reg ? 8'd0 : tbl_entry.x;
        end
    end

    // a result word only shows while the sequencer sits in its output state
    a_out_state: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (state_reg == ST_Q_OUT))
        else $error("result word outside output state");

    // a line count never grows past the per line limit
    a_cnt_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_we |-> (cnt_wdata <= CW'(LINE_LIMIT)))
        else $error("line count above limit");

    // a query command starts the count lookup in the next cycle
    a_query_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_data.command == CMD_QUERY) |=> (state_reg == ST_Q_CNT))
        else $error("query did not start count lookup");

    // the scan never runs past the listed sprites
    a_scan_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_Q_SCAN) |-> (p_reg < n_reg && i_reg < n_reg))
        else $error("scan index beyond line list");

    // a word that is not last always leads back into another scan
    a_next_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_ready && !m_data_reg.last) |=> (state_reg == ST_Q_SCAN))
        else $error("missing scan after non last word");

endmodule

`default_nettype wire

>>> tb/sprite_line_mapper_checker.sv
// checker of the sprite line mapper: watches the channels, predicts query words and compares
module sprite_line_mapper_checker
    import slm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  slm_in_t  s_data,
    input  logic     m_valid,
    input  logic     m_ready,
    input  slm_out_t m_data,
    input  logic     cfg_valid,
    input  logic     cfg_ready,
    input  logic     cfg_data,
    output int       errors,
    output int       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    slm_entry_t sprite_tab [SLM_SPRITE_ENTRIES];
    logic [5:0] line_sprites [SLM_VISIBLE_LINES][SLM_LINE_LIMIT];
    logic [3:0] line_fill [SLM_VISIBLE_LINES];
    logic       color_order;
    slm_out_t   line_words_due [$];

    task automatic rebuild_line_map();
        int s, k, top_line, ln, h;
        for (ln = 0; ln < SLM_VISIBLE_LINES; ln++) line_fill[ln] = '0;
        for (s = 0; s < SLM_SPRITE_ENTRIES; s++) begin
            top_line = int'(sprite_tab[s].y) - SLM_Y_OFFSET;
            h = sprite_tab[s].tall ? SLM_TALL_H : SLM_SHORT_H;
            for (k = 0; k < h; k++) begin
                ln = top_line + k;
                if (ln >= 0 && ln < SLM_VISIBLE_LINES && line_fill[ln] < SLM_LINE_LIMIT) begin
                    line_sprites[ln][line_fill[ln]] = 6'(s);
                    line_fill[ln] = line_fill[ln] + 4'd1;
                end
            end
        end
    endtask

    task automatic answer_query(input logic [7:0] ln);
        int n, i, j;
        logic [5:0] v;
        logic [5:0] lst [SLM_LINE_LIMIT];
        slm_out_t w;
        if (ln >= SLM_VISIBLE_LINES || line_fill[ln] == 0) begin
            // empty line: a single word with found cleared
            w.found_sprite = '0;
            w.found = 1'b0;
            w.line_count = '0;
            w.last = 1'b1;
            line_words_due.push_back(w);
        end else begin
            n = line_fill[ln];
            for (i = 0; i < n; i++) lst[i] = line_sprites[ln][i];
            if (!color_order) begin
                // stable insertion sort on the x held in the table right now
                for (i = 1; i < n; i++) begin
                    v = lst[i];
                    j = i;
                    while (j > 0 && sprite_tab[v].x < sprite_tab[lst[j-1]].x) begin
                        lst[j] = lst[j-1];
                        j--;
                    end
                    lst[j] = v;
                end
            end
            for (i = 0; i < n; i++) begin
                w.found_sprite = lst[i];
                w.found = 1'b1;
                w.line_count = 4'(n);
                w.last = (i == n - 1);
                line_words_due.push_back(w);
            end
        end
    endtask

    always @(posedge aclk) begin
        slm_out_t want;
        if (!aresetn) begin
            foreach (sprite_tab[s]) sprite_tab[s] = '0;
            foreach (line_fill[l]) line_fill[l] = '0;
            color_order = 1'b0;
            line_words_due.delete();
            errors = 0;
        end else begin
            if (cfg_valid && cfg_ready) color_order = cfg_data;
            if (s_valid && s_ready) begin
                case (s_data.command)
                    CMD_WRITE: begin
                        if (s_data.sprite_number < SLM_SPRITE_ENTRIES) begin
                            sprite_tab[s_data.sprite_number].y = s_data.vertical_position;
                            sprite_tab[s_data.sprite_number].x = s_data.horizontal_position;
                            sprite_tab[s_data.sprite_number].tall = s_data.tall_sprite;
                        end
                    end
                    CMD_BUILD: rebuild_line_map();
                    CMD_QUERY: answer_query(s_data.query_line);
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (line_words_due.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: unexpected word s%0d f%0b c%0d l%0b",
                                 $realtime, m_data.found_sprite, m_data.found,
                                 m_data.line_count, m_data.last);
                    errors++;
                end else begin
                    want = line_words_due.pop_front();
                    if (m_data.found_sprite !== want.found_sprite || m_data.found !== want.found ||
                        m_data.line_count !== want.line_count || m_data.last !== want.last) begin
                        if (errors < 10)
                            $display("%0t: exp s%0d f%0b c%0d l%0b got s%0d f%0b c%0d l%0b",
                                     $realtime, want.found_sprite, want.found, want.line_count,
                                     want.last, m_data.found_sprite, m_data.found,
                                     m_data.line_count, m_data.last);
                        errors++;
                    end
                end
            end
        end
        pending = line_words_due.size();
    end

endmodule

>>> tb/sprite_line_mapper_top_tb.sv
// testbench top of the sprite line mapper: stimulus, receiver stalls and verdict
module sprite_line_mapper_top_tb
    import slm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // command code the block has no meaning for, must be swallowed
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // slack for a build, which runs with no word coming out
    localparam int BUILD_SLACK = 1400;
    // items of random traffic per phase
    localparam int PHASE_ITEMS = 24;

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    slm_in_t  s_data;
    logic     m_valid;
    logic     m_ready = 1'b0;
    slm_out_t m_data;
    logic     cfg_valid;
    logic     cfg_ready;
    logic     cfg_data;

    int errors;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    int words_sent;

    // idle percentages and color mode per phase: receiver-heavy, sender-heavy, none
    int tx_pct [3] = '{37, 45, 0};
    int rx_pct [3] = '{45, 37, 0};
    int mode_of [3] = '{0, 1, 0};

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    sprite_line_mapper_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sprite_line_mapper_checker line_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    // receiver stalls, redrawn every falling edge
    always @(negedge aclk) m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);

    // hard stop in case the block hangs
    initial begin
        #(10_000_000);
        $display("sprite_line_mapper_top_tb failed");
        $finish;
    end

    // every field random, so unused fields still toggle
    function automatic slm_in_t noise_word();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(slm_in_t)-1:0];
    endfunction

    // entered and left at a falling edge; valid stays up when words go back to back
    task automatic send_word(input slm_in_t w);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        @(negedge aclk);
    endtask

    task automatic write_sprite(input int num, input int y, input int x, input logic tall);
        slm_in_t w;
        w = noise_word();
        w.command = CMD_WRITE;
        w.sprite_number = 6'(num);
        w.vertical_position = 8'(y);
        w.horizontal_position = 8'(x);
        w.tall_sprite = tall;
        send_word(w);
    endtask

    task automatic issue_command(input logic [1:0] cmd);
        slm_in_t w;
        w = noise_word();
        w.command = cmd;
        send_word(w);
    endtask

    task automatic query_line(input int ln);
        slm_in_t w;
        w = noise_word();
        w.command = CMD_QUERY;
        w.query_line = 8'(ln);
        send_word(w);
    endtask

    // stop sending, let every query word drain, then cover a build that may still run
    task automatic drain();
        s_valid = 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (BUILD_SLACK) @(negedge aclk);
    endtask

    task automatic set_color_mode(input logic v);
        drain();
        cfg_valid = 1'b1;
        cfg_data = v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic directed_words();
        int i;
        // three sprites starting at line 0, two of them tied on x
        write_sprite(0, 16, 255, 1'b1);
        write_sprite(1, 16, 0, 1'b0);
        write_sprite(2, 16, 0, 1'b0);
        // fully below the screen, only the last line visible, fully above
        write_sprite(39, 255, 128, 1'b1);
        write_sprite(38, 159, 7, 1'b1);
        write_sprite(37, 0, 9, 1'b1);
        // out of range entries, would land on lines 4..19 if not ignored
        write_sprite(63, 20, 1, 1'b1);
        write_sprite(40, 20, 2, 1'b0);
        issue_command(CMD_UNUSED);
        // crowd lines 4..11 so line 7 overflows its limit
        for (i = 3; i <= 10; i++) write_sprite(i, 20, (i % 3) * 50, 1'b0);
        issue_command(CMD_BUILD);
        query_line(0);
        query_line(7);
        query_line(143);
        // past the visible area on both the first and the top bit
        query_line(144);
        query_line(255);
    endtask

    // writes clustered around one spot, a build, then queries of the lines it touches
    task automatic random_batch();
        int base_y, base_x, nw, nq, i, roll, ln;
        base_y = $urandom_range(0, 175);
        base_x = $urandom_range(0, 255);
        nw = $urandom_range(2, 8);
        for (i = 0; i < nw; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                write_sprite($urandom_range(40, 63), $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 1));
            else if (roll < 12)
                issue_command(CMD_UNUSED);
            else
                write_sprite($urandom_range(0, 39),
                             (roll < 20) ? $urandom_range(0, 255) : base_y + $urandom_range(0, 10),
                             ($urandom_range(0, 3) == 0) ? base_x : $urandom_range(0, 255),
                             $urandom_range(0, 1));
        end
        if ($urandom_range(0, 9) != 0) issue_command(CMD_BUILD);
        // moving a sprite after the build changes the sort key but not the lists
        if ($urandom_range(0, 3) == 0)
            write_sprite($urandom_range(0, 39), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 1));
        nq = $urandom_range(2, 5);
        for (i = 0; i < nq; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                ln = $urandom_range(0, 255);
            end else begin
                ln = base_y - SLM_Y_OFFSET + $urandom_range(0, 15);
                if (ln < 0) ln = 0;
            end
            query_line(ln);
        end
    endtask

    initial begin
        int phase, target;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        tx_idle_pct = tx_pct[0];
        rx_idle_pct = rx_pct[0];
        words_sent = 0;
        repeat (11) @(negedge aclk);
        aresetn = 1'b1;

        for (phase = 0; phase < 3; phase++) begin
            tx_idle_pct = tx_pct[phase];
            rx_idle_pct = rx_pct[phase];
            // color mode only changes while nothing is in flight
            set_color_mode(mode_of[phase][0]);
            if (phase == 0) directed_words();
            target = words_sent + PHASE_ITEMS;
            while (words_sent < target) random_batch();
        end

        drain();
        if (errors == 0) begin
            $display("sprite_line_mapper_top_tb passed");
        end else begin
            $display("sprite_line_mapper_top_tb failed");
        end
        $finish;
    end

endmodule
